/* hw/rtl/pfla_pkg.sv */
// Shared widths, codes and the queue entry type of the page free list allocator.
package pfla_pkg;

   localparam int unsigned ADDR_W             = 32;
   localparam int unsigned CMD_W              = 2;
   localparam int unsigned STATUS_W           = 3;
   localparam int unsigned COUNT_W            = 11;
   localparam int unsigned CSR_INDEX_W        = 2;
   localparam int unsigned OP_W               = 2;

   localparam int unsigned CAPACITY_DEFAULT   = 1024;
   localparam int unsigned PAGE_SHIFT_DEFAULT = 12;

   localparam logic [ADDR_W-1:0] KERNEL_BASE_RESET = 32'h8000_0000;

   // Request commands.
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNALIGNED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LOW       = 3'd4;
   localparam logic [STATUS_W-1:0] ST_HIGH      = 3'd5;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd6;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_BOUND   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_BOUND  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_BASE = 2'd2;

   // Operations handed from the front to the back.
   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OP_W-1:0] OP_PUSH   = 2'd1;
   localparam logic [OP_W-1:0] OP_ADD    = 2'd2;
   localparam logic [OP_W-1:0] OP_REPORT = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   address;
   } pfla_op_type;

endpackage

/* hw/rtl/pfla_if.sv */
// Request and response channel interfaces of the page free list allocator.
interface pfla_req_if;
   import pfla_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [ADDR_W-1:0]   page_address;

   modport source (output valid, command, page_address, input ready);
   modport sink   (input valid, command, page_address, output ready);
endinterface

interface pfla_rsp_if;
   import pfla_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   alloc_address;
   logic [COUNT_W-1:0]  free_count;
   logic [COUNT_W-1:0]  total_count;

   modport source (output valid, status, alloc_address, free_count, total_count, input ready);
   modport sink   (input valid, status, alloc_address, free_count, total_count, output ready);
endinterface

/* hw/rtl/pfla_front.sv */
// Front end: configuration registers and classification of incoming requests.
module pfla_front #(
   parameter int unsigned PAGE_SHIFT = pfla_pkg::PAGE_SHIFT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pfla_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pfla_pkg::ADDR_W-1:0]         csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pfla_pkg::CMD_W-1:0]          req_command,
   input  logic [pfla_pkg::ADDR_W-1:0]         req_page_address,
   output logic                                push_valid,
   input  logic                                push_ready,
   output pfla_pkg::pfla_op_type               push_data
);
   import pfla_pkg::*;

   logic [ADDR_W-1:0] low_bound_ff;
   logic [ADDR_W-1:0] high_bound_ff;
   logic [ADDR_W-1:0] kernel_base_ff;
   logic [ADDR_W-1:0] phys_address;
   logic [STATUS_W-1:0] check_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_bound_ff   <= '0;
         high_bound_ff  <= '0;
         kernel_base_ff <= KERNEL_BASE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOW_BOUND:   low_bound_ff   <= csr_wdata;
            CSR_HIGH_BOUND:  high_bound_ff  <= csr_wdata;
            CSR_KERNEL_BASE: kernel_base_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign phys_address = req_page_address - kernel_base_ff;

   // The store-full check needs the stack pointer and is left to the back end.
   always_comb begin
      priority if (req_page_address == '0) begin
         check_status = ST_NULL;
      end else if (req_page_address[PAGE_SHIFT-1:0] != '0) begin
         check_status = ST_UNALIGNED;
      end else if (req_page_address < low_bound_ff) begin
         check_status = ST_LOW;
      end else if (phys_address >= high_bound_ff) begin
         check_status = ST_HIGH;
      end else begin
         check_status = ST_OK;
      end
   end

   always_comb begin
      push_data.address = req_page_address;
      push_data.status  = ST_OK;
      push_data.op      = OP_REPORT;
      unique case (req_command)
         CMD_ALLOC: push_data.op = OP_ALLOC;
         CMD_FREE, CMD_ADD: begin
            push_data.status = check_status;
            if (check_status != ST_OK) begin
               push_data.op = OP_REPORT;
            end else if (req_command == CMD_ADD) begin
               push_data.op = OP_ADD;
            end else begin
               push_data.op = OP_PUSH;
            end
         end
         default: push_data.op = OP_REPORT;
      endcase
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

/* hw/rtl/pfla_queue.sv */
// Two-entry queue of classified operations between the front and back ends.
module pfla_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  pfla_pkg::pfla_op_type push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output pfla_pkg::pfla_op_type pop_data
);
   import pfla_pkg::*;

   pfla_op_type entry_ff [2];
   logic        wr_ptr_ff;
   logic        wr_ptr_in;
   logic        rd_ptr_ff;
   logic        rd_ptr_in;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;
   logic        do_push;
   logic        do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/pfla_back.sv */
// Back end: page stack memory, stack pointer, added-page total and response register.
module pfla_back #(
   parameter int unsigned CAPACITY   = pfla_pkg::CAPACITY_DEFAULT,
   parameter int unsigned PAGE_SHIFT = pfla_pkg::PAGE_SHIFT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               op_valid,
   output logic                               op_ready,
   input  pfla_pkg::pfla_op_type              op_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [pfla_pkg::STATUS_W-1:0]      rsp_status,
   output logic [pfla_pkg::ADDR_W-1:0]        rsp_alloc_address,
   output logic [pfla_pkg::COUNT_W-1:0]       rsp_free_count,
   output logic [pfla_pkg::COUNT_W-1:0]       rsp_total_count
);
   import pfla_pkg::*;

   localparam int unsigned PTR_W = $clog2(CAPACITY + 1);
   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned PN_W  = ADDR_W - PAGE_SHIFT;
   localparam logic [PTR_W-1:0] PTR_FULL = PTR_W'(CAPACITY);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_POP  = 1'b1;

   logic [PN_W-1:0]  stack_mem [CAPACITY];
   logic [PN_W-1:0]  rd_data_ff;

   logic             state_ff;
   logic             state_in;
   logic [PTR_W-1:0] ptr_ff;
   logic [PTR_W-1:0] ptr_in;
   logic [PTR_W-1:0] total_ff;
   logic [PTR_W-1:0] total_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic [ADDR_W-1:0]   alloc_ff;
   logic [ADDR_W-1:0]   alloc_in;
   logic [COUNT_W-1:0]  free_cnt_ff;
   logic [COUNT_W-1:0]  free_cnt_in;
   logic [COUNT_W-1:0]  total_cnt_ff;
   logic [COUNT_W-1:0]  total_cnt_in;

   logic             out_free;
   logic             load_out;
   logic             mem_we;
   logic             mem_re;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;
   logic [PTR_W-1:0] ptr_dec;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign ptr_dec  = ptr_ff - PTR_W'(1);
   assign wr_idx   = ptr_ff[IDX_W-1:0];
   assign rd_idx   = ptr_dec[IDX_W-1:0];

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      total_in  = total_ff;
      op_ready  = 1'b0;
      load_out  = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      status_in = ST_OK;
      alloc_in  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (op_valid) begin
               if (op_data.op == OP_ALLOC && ptr_ff != '0) begin
                  // Read the top entry now; the response goes out once it is back.
                  op_ready = 1'b1;
                  mem_re   = 1'b1;
                  ptr_in   = ptr_dec;
                  state_in = S_POP;
               end else if (out_free) begin
                  op_ready = 1'b1;
                  load_out = 1'b1;
                  unique case (op_data.op)
                     OP_ALLOC: status_in = ST_EMPTY;
                     OP_PUSH, OP_ADD: begin
                        if (ptr_ff == PTR_FULL) begin
                           status_in = ST_FULL;
                        end else begin
                           mem_we = 1'b1;
                           ptr_in = ptr_ff + PTR_W'(1);
                           if (op_data.op == OP_ADD && total_ff != PTR_FULL) begin
                              total_in = total_ff + PTR_W'(1);
                           end
                        end
                     end
                     default: status_in = op_data.status;
                  endcase
               end
            end
         end
         default: begin
            if (out_free) begin
               load_out = 1'b1;
               alloc_in = {rd_data_ff, {PAGE_SHIFT{1'b0}}};
               state_in = S_IDLE;
            end
         end
      endcase

      free_cnt_in  = COUNT_W'(ptr_in);
      total_cnt_in = COUNT_W'(total_in);

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ptr_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         status_ff    <= status_in;
         alloc_ff     <= alloc_in;
         free_cnt_ff  <= free_cnt_in;
         total_cnt_ff <= total_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_idx] <= op_data.address[ADDR_W-1:PAGE_SHIFT];
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem[rd_idx];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_alloc_address = alloc_ff;
   assign rsp_free_count    = free_cnt_ff;
   assign rsp_total_count   = total_cnt_ff;

endmodule

/* hw/rtl/page_free_list_allocator_unit.sv */
// Top level of the page free list allocator: front end, operation queue and back end.
// A request is checked in the front end, queued, and answered from the back end's response
// register; an allocate from a non-empty stack also waits for the registered stack read.
// Throughput: one free, add or rejected request per cycle while responses are taken; a
// successful allocate holds the back end in its pop state for the registered stack read.
// Reset is synchronous and active high; it empties the stack, clears the total and sets
// the bounds to their reset values. The stack memory itself is not cleared.
module page_free_list_allocator_unit #(
   parameter int unsigned CAPACITY   = pfla_pkg::CAPACITY_DEFAULT,
   parameter int unsigned PAGE_SHIFT = pfla_pkg::PAGE_SHIFT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [pfla_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pfla_pkg::ADDR_W-1:0]      csr_wdata,
   pfla_req_if.sink                         req_ch,
   pfla_rsp_if.source                       rsp_ch
);
   import pfla_pkg::*;

   // Classified request leaving the front end and entering the queue.
   logic        fq_valid;
   logic        fq_ready;
   pfla_op_type fq_data;

   // Head of the queue presented to the back end.
   logic        qb_valid;
   logic        qb_ready;
   pfla_op_type qb_data;

   // The front end holds the bounds and performs every address check that does not
   // depend on the stack. Its ready follows the queue, so a request is accepted
   // whenever the queue has room, even while the back end stalls on the response.
   pfla_front #(
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_command      (req_ch.command),
      .req_page_address (req_ch.page_address),
      .push_valid       (fq_valid),
      .push_ready       (fq_ready),
      .push_data        (fq_data)
   );

   // A two-entry queue decouples classification from execution.
   pfla_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   // The back end owns the stack and its pointer, applies the full check, and drives
   // the response register.
   pfla_back #(
      .CAPACITY   (CAPACITY),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .op_valid          (qb_valid),
      .op_ready          (qb_ready),
      .op_data           (qb_data),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_status        (rsp_ch.status),
      .rsp_alloc_address (rsp_ch.alloc_address),
      .rsp_free_count    (rsp_ch.free_count),
      .rsp_total_count   (rsp_ch.total_count)
   );

endmodule

/* sim/pfla_result_checker.sv */
// Watches the request and response channels of the allocator, predicts each response and compares.
module pfla_result_checker #(
   parameter int unsigned CAPACITY   = pfla_pkg::CAPACITY_DEFAULT,
   parameter int unsigned PAGE_SHIFT = pfla_pkg::PAGE_SHIFT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [pfla_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pfla_pkg::ADDR_W-1:0]      csr_wdata,
   pfla_req_if                              req_mon,
   pfla_rsp_if                              rsp_mon,
   output int unsigned                      mismatch_count,
   output int unsigned                      outstanding
);
   import pfla_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   alloc_address;
      logic [COUNT_W-1:0]  free_count;
      logic [COUNT_W-1:0]  total_count;
   } pfla_response_type;

   // Shadow copy of the allocator state and its bounds.
   logic [ADDR_W-PAGE_SHIFT-1:0] shadow_stack [CAPACITY];
   int unsigned                  shadow_depth;
   int unsigned                  shadow_total;
   logic [ADDR_W-1:0]            bound_low;
   logic [ADDR_W-1:0]            bound_high;
   logic [ADDR_W-1:0]            base_offset;

   pfla_response_type predicted_responses [$];
   pfla_response_type oldest;
   int unsigned       errors_seen = 0;

   // The checks run in a fixed order and the first one that fails gives the status.
   function automatic logic [STATUS_W-1:0] push_page(input logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] phys;
      phys = addr - base_offset;
      if (addr == '0) return ST_NULL;
      if (addr[PAGE_SHIFT-1:0] != '0) return ST_UNALIGNED;
      if (addr < bound_low) return ST_LOW;
      if (phys >= bound_high) return ST_HIGH;
      if (shadow_depth >= CAPACITY) return ST_FULL;
      shadow_stack[shadow_depth] = addr[ADDR_W-1:PAGE_SHIFT];
      shadow_depth++;
      return ST_OK;
   endfunction

   function automatic pfla_response_type next_response(input logic [CMD_W-1:0] cmd,
                                                       input logic [ADDR_W-1:0] addr);
      pfla_response_type rsp;
      rsp.status        = ST_OK;
      rsp.alloc_address = '0;
      case (cmd)
         CMD_ALLOC: begin
            if (shadow_depth == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               shadow_depth--;
               rsp.alloc_address = {shadow_stack[shadow_depth], {PAGE_SHIFT{1'b0}}};
            end
         end
         CMD_FREE: begin
            rsp.status = push_page(addr);
         end
         CMD_ADD: begin
            rsp.status = push_page(addr);
            if (rsp.status == ST_OK && shadow_total < CAPACITY) shadow_total++;
         end
         default: begin
         end
      endcase
      rsp.free_count  = COUNT_W'(shadow_depth);
      rsp.total_count = COUNT_W'(shadow_total);
      return rsp;
   endfunction

   function automatic void compare_field(input string field, input logic [ADDR_W-1:0] want,
                                         input logic [ADDR_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         errors_seen++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         shadow_depth = 0;
         shadow_total = 0;
         bound_low    = '0;
         bound_high   = '0;
         base_offset  = KERNEL_BASE_RESET;
         predicted_responses.delete();
      end else begin
         // A response always belongs to a request accepted at an earlier edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_responses.size() == 0) begin
               $error("response accepted with no request outstanding");
               errors_seen++;
            end else begin
               oldest = predicted_responses.pop_front();
               compare_field("status", ADDR_W'(oldest.status), ADDR_W'(rsp_mon.status));
               compare_field("alloc_address", oldest.alloc_address, rsp_mon.alloc_address);
               compare_field("free_count", ADDR_W'(oldest.free_count),
                             ADDR_W'(rsp_mon.free_count));
               compare_field("total_count", ADDR_W'(oldest.total_count),
                             ADDR_W'(rsp_mon.total_count));
            end
         end
         if (req_mon.valid && req_mon.ready)
            predicted_responses.push_back(next_response(req_mon.command, req_mon.page_address));
         if (csr_we) begin
            case (csr_index)
               CSR_LOW_BOUND:   bound_low   = csr_wdata;
               CSR_HIGH_BOUND:  bound_high  = csr_wdata;
               CSR_KERNEL_BASE: base_offset = csr_wdata;
               default: begin
               end
            endcase
         end
      end
      mismatch_count <= errors_seen;
      outstanding    <= predicted_responses.size();
   end

endmodule

/* sim/page_free_list_allocator_unit_test.sv */
// Testbench top of the page free list allocator: clock, reset, stimulus and the verdict.
module page_free_list_allocator_unit_test;
   import pfla_pkg::*;

   // Command code three has no operation behind it; the block must answer it with no change.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int unsigned PAGE_W = ADDR_W - PAGE_SHIFT_DEFAULT;

   // Once, deep in the fill phase, the response side stops taking responses for a long
   // stretch so that the internal queue fills and the request side is stalled.
   localparam int unsigned LONG_HOLD_AT     = 700;
   localparam int unsigned LONG_HOLD_CYCLES = 400;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [ADDR_W-1:0]      csr_wdata;

   pfla_req_if request_bus ();
   pfla_rsp_if response_bus ();

   int unsigned mismatch_count;
   int unsigned outstanding;

   int unsigned sends_made = 0;
   bit          send_burst = 1'b0;

   page_free_list_allocator_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (request_bus),
      .rsp_ch    (response_bus)
   );

   pfla_result_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_mon        (request_bus),
      .rsp_mon        (response_bus),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run. The slowest legal run is well under a tenth of this.
   initial begin
      #5000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Offers one request and returns at the edge where it is accepted. The valid line is
   // only lowered when a gap follows, so that back-to-back requests keep it high and each
   // time step sees a single assignment to it. Every 64 requests the sender decides whether
   // the next stretch runs without any gaps.
   task automatic offer_request(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
      int unsigned gap;
      if (sends_made % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
      sends_made++;
      gap = send_burst ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         request_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      request_bus.valid        <= 1'b1;
      request_bus.command      <= cmd;
      request_bus.page_address <= addr;
      do @(posedge clock); while (!request_bus.ready);
   endtask

   function automatic logic [CMD_W-1:0] pick_push();
      return ($urandom_range(0, 1) != 0) ? CMD_ADD : CMD_FREE;
   endfunction

   // A malformed or odd request: null, unaligned, the unused command, fully random
   // content, or an aligned page that most likely falls outside the bounds.
   task automatic offer_noise();
      logic [ADDR_W-1:0] addr;
      addr = $urandom;
      case ($urandom_range(0, 4))
         0: offer_request(pick_push(), '0);
         1: offer_request(pick_push(), addr | (32'd1 << $urandom_range(0, PAGE_SHIFT_DEFAULT - 1)));
         2: offer_request(CMD_UNUSED, addr);
         3: offer_request(CMD_W'($urandom_range(0, 3)), addr);
         default: offer_request(pick_push(),
                                {addr[ADDR_W-1:PAGE_SHIFT_DEFAULT], {PAGE_SHIFT_DEFAULT{1'b0}}});
      endcase
   endtask

   // Random traffic for one bound setting. Most pushes carry a page that passes every
   // check under that setting, so the stack really moves; allocates carry random address
   // bits, which the block must ignore.
   task automatic run_mixed(input int unsigned count, input int unsigned alloc_pct,
                            input int unsigned noise_pct, input int unsigned add_pct,
                            input logic [PAGE_W-1:0] first_page, input int unsigned page_span);
      int unsigned       roll;
      logic [PAGE_W-1:0] page;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         page = first_page + PAGE_W'($urandom_range(0, page_span - 1));
         if (roll < alloc_pct)
            offer_request(CMD_ALLOC, $urandom);
         else if (roll < alloc_pct + noise_pct)
            offer_noise();
         else
            offer_request(($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_FREE,
                          {page, {PAGE_SHIFT_DEFAULT{1'b0}}});
      end
   endtask

   // Stops offering and waits until every predicted response has been taken, then lets the
   // back end idle. A wait at the start lets the outstanding count catch up with a request
   // accepted at the current edge.
   task automatic settle();
      request_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all three bounds on consecutive edges; the write enable stays high throughout.
   task automatic program_bounds(input logic [ADDR_W-1:0] low, input logic [ADDR_W-1:0] high,
                                 input logic [ADDR_W-1:0] base);
      csr_we    <= 1'b1;
      csr_index <= CSR_LOW_BOUND;
      csr_wdata <= low;
      @(posedge clock);
      csr_index <= CSR_HIGH_BOUND;
      csr_wdata <= high;
      @(posedge clock);
      csr_index <= CSR_KERNEL_BASE;
      csr_wdata <= base;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Response side: a random stall before each response, stretches without stalls, and
   // one long hold-off that reuses the same stall loop.
   initial begin : response_sink
      int unsigned taken;
      int unsigned gap;
      bit          eager;
      taken = 0;
      eager = 1'b0;
      response_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (taken % 50 == 0) eager = ($urandom_range(0, 3) == 0);
         gap = eager ? 0 : $urandom_range(0, 17);
         if (taken == LONG_HOLD_AT) gap = LONG_HOLD_CYCLES;
         if (gap != 0) begin
            response_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         response_bus.ready <= 1'b1;
         do @(posedge clock); while (!response_bus.valid);
         taken++;
      end
   end

   initial begin : stimulus
      reset                    <= 1'b1;
      csr_we                   <= 1'b0;
      csr_index                <= CSR_LOW_BOUND;
      csr_wdata                <= '0;
      request_bus.valid        <= 1'b0;
      request_bus.command      <= CMD_ALLOC;
      request_bus.page_address <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Bounds at their reset values: the high bound of zero rejects every aligned page.
      offer_request(CMD_ALLOC, 32'hFFFF_FFFF);     // empty stack
      offer_request(CMD_FREE, 32'h0000_0000);      // null address
      offer_request(CMD_ADD, 32'h0000_0000);       // null address, nothing counted
      offer_request(CMD_FREE, 32'hFFFF_FFFF);      // unaligned, every bit set
      offer_request(CMD_ADD, 32'h0000_0800);       // unaligned
      offer_request(CMD_UNUSED, 32'hFFFF_F000);    // unused command
      offer_request(CMD_FREE, 32'h8000_0000);      // physical zero is not below zero
      settle();

      // Kernel image ends at 0x8010_0000, 16 MiB of physical memory.
      program_bounds(32'h8010_0000, 32'h0100_0000, 32'h8000_0000);
      offer_request(CMD_FREE, 32'h8000_F000);      // below the low bound
      offer_request(CMD_FREE, 32'h8100_0000);      // exactly at the high bound
      offer_request(CMD_ADD, 32'h8010_0000);       // exactly at the low bound
      offer_request(CMD_FREE, 32'h80FF_F000);      // last page below the high bound
      offer_request(CMD_FREE, 32'h8010_0800);      // unaligned, though within the bounds
      offer_request(CMD_ALLOC, 32'h0000_0000);     // last in, first out
      offer_request(CMD_ALLOC, 32'h1234_5678);
      offer_request(CMD_ALLOC, 32'h0000_0000);     // empty again
      offer_request(CMD_ADD, 32'h8020_0000);
      settle();

      // Widest bounds: every aligned nonzero page passes, so mostly adds fill the stack,
      // run into the full store and drive the total to its saturation point.
      program_bounds(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
      run_mixed(1150, 2, 2, 100, PAGE_W'(1), 32'h000F_FFFF);
      settle();

      // Back to the narrow window with a full stack: allocates outnumber pushes.
      program_bounds(32'h8010_0000, 32'h0100_0000, 32'h8000_0000);
      run_mixed(60, 55, 15, 50, PAGE_W'(32'h80100), 32'h0000_0F00);
      settle();

      // A kernel base above the low bound, so the physical address wraps below it.
      program_bounds(32'h0000_1000, 32'h4000_0000, 32'hC000_0000);
      offer_request(CMD_ADD, 32'h0000_1000);       // wraps to above the high bound
      offer_request(CMD_FREE, 32'hBFFF_F000);      // wraps to the top of the space
      offer_request(CMD_ALLOC, 32'h0000_0000);     // make room in case the stack is full
      offer_request(CMD_ADD, 32'hFFFF_F000);       // highest page address
      offer_request(CMD_ALLOC, 32'h0000_0000);     // returns the highest page
      offer_request(CMD_FREE, 32'hC000_0000);      // physical zero
      run_mixed(40, 50, 15, 50, PAGE_W'(32'hC0000), 32'h0004_0000);
      settle();

      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
